[hdl/cda_pkg.sv]
// Shared types, constants and the arctangent step table for the atan2 pipeline.
// No dependencies; imported by every module of the block.
package cda_pkg;

	// residual angle, pi = 0x10000, partial sums stay well inside 17 bits
	localparam int RESID_W = 17;
	// result angle in degrees, 10.16 fixed point
	localparam int ANGLE_W = 26;
	// octant base in 45 degree steps
	localparam int BASE_W  = 3;
	localparam int FRAC_ONE    = 65536;
	localparam int DEG_PER_STEP = 45;
	localparam int RESID_SCALE = 180;

	typedef logic signed [RESID_W-1:0] resid_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;

	localparam angle_t HALF_TURN = angle_t'(180 * FRAC_ONE);

	// control carried alongside the vector through the pipe
	typedef struct packed {
		logic              zero_y;
		logic              x_neg;
		logic [BASE_W-1:0] base;
	} cda_ctl_t;

	// atan(2^-s), scaled so that pi equals 0x10000
	function automatic resid_t arc_step(input int unsigned s);
		resid_t r;
		case (s)
			0:       r = resid_t'(17'h04000);
			1:       r = resid_t'(17'h025C8);
			2:       r = resid_t'(17'h013F6);
			3:       r = resid_t'(17'h00A22);
			4:       r = resid_t'(17'h00516);
			5:       r = resid_t'(17'h0028C);
			6:       r = resid_t'(17'h00146);
			7:       r = resid_t'(17'h000A3);
			8:       r = resid_t'(17'h00051);
			9:       r = resid_t'(17'h00029);
			10:      r = resid_t'(17'h00014);
			11:      r = resid_t'(17'h0000A);
			12:      r = resid_t'(17'h00005);
			13:      r = resid_t'(17'h00003);
			14:      r = resid_t'(17'h00001);
			15:      r = resid_t'(17'h00001);
			default: r = '0;
		endcase
		return r;
	endfunction

	// octant base converted to degrees, 10.16
	function automatic angle_t base_angle(input logic [BASE_W-1:0] b);
		return angle_t'(int'(b) * DEG_PER_STEP * FRAC_ONE);
	endfunction

endpackage

[hdl/cda_fold.sv]
// Input fold: moves the vector into the first octant and records the octant base.
// Depends on cda_pkg.
module cda_fold #(
	parameter int CW = 16,
	parameter int IW = 19
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_in,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	output logic                 valid_q,
	output cda_pkg::cda_ctl_t    ctl_q,
	output logic signed [IW-1:0] vx_q,
	output logic signed [IW-1:0] vy_q
);
	import cda_pkg::*;

	logic signed [IW-1:0] ax, ay, bx, by, cx, cy;
	logic neg, swap, rot;
	cda_ctl_t ctl_d;

	// negate lower half plane, turn by -90, then unscaled -45 rotation
	always_comb begin
		ax   = IW'(x_in);
		ay   = IW'(y_in);
		neg  = y_in[CW-1];
		if (neg) begin
			ax = -IW'(x_in);
			ay = -IW'(y_in);
		end
		swap = (ax <= 0);
		bx   = ax;
		by   = ay;
		if (swap) begin
			bx = ay;
			by = -ax;
		end
		rot = (bx <= by);
		cx  = bx;
		cy  = by;
		if (rot) begin
			cx = bx + by;
			cy = by - bx;
		end
		ctl_d.zero_y = (y_in == '0);
		ctl_d.x_neg  = x_in[CW-1];
		ctl_d.base   = {neg, swap, rot};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		ctl_q <= ctl_d;
		vx_q  <= cx;
		vy_q  <= cy;
	end

`ifndef NO_ASSERTIONS
	// folded vector lies in the first octant
	a_octant: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !ctl_q.zero_y |-> !vy_q[IW-1] && (vy_q < vx_q))
		else $error("fold left the vector outside the first octant");
`endif

endmodule

[hdl/cda_cell.sv]
// One CORDIC vectoring cell: a single shift-add iteration with its own register.
// Depends on cda_pkg.
module cda_cell #(
	parameter int IW    = 19,
	parameter int SHIFT = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_in,
	input  cda_pkg::cda_ctl_t    ctl_in,
	input  logic signed [IW-1:0] vx_in,
	input  logic signed [IW-1:0] vy_in,
	input  cda_pkg::resid_t      resid_in,
	output logic                 valid_q,
	output cda_pkg::cda_ctl_t    ctl_q,
	output logic signed [IW-1:0] vx_q,
	output logic signed [IW-1:0] vy_q,
	output cda_pkg::resid_t      resid_q
);
	import cda_pkg::*;

	logic signed [IW-1:0] dx, dy, nx, ny;
	resid_t nr;

	// rotate toward the x axis by atan(2^-SHIFT)
	always_comb begin
		dx = vx_in >>> SHIFT;
		dy = vy_in >>> SHIFT;
		if (!vy_in[IW-1]) begin
			nx = vx_in + dy;
			ny = vy_in - dx;
			nr = resid_in + arc_step(SHIFT);
		end else begin
			nx = vx_in - dy;
			ny = vy_in + dx;
			nr = resid_in - arc_step(SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		ctl_q   <= ctl_in;
		vx_q    <= nx;
		vy_q    <= ny;
		resid_q <= nr;
	end

endmodule

[hdl/cordic_atan2_degrees.sv]
// Top level: fold stage, a chain of CORDIC cells and the degree conversion stage.
// Depends on cda_pkg, cda_fold and cda_cell.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------
//  vector   | start in, busy out  | x_coord, y_coord
//  angle    | done out (strobe)   | angle_deg
//
// One item enters per clock; busy is never raised.
// The path holds one fold register, ITERATIONS - 1 cells and
// one register for the conversion to degrees.
// Reset clears the valid bits of the pipe; payload registers are not reset.
// done is high for one cycle per item; the receiver has no way to stall.
module cordic_atan2_degrees #(
	parameter int ITERATIONS  = 12,
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	output logic                          done,
	output cda_pkg::angle_t               angle_deg
);
	import cda_pkg::*;

	localparam int IW      = COORD_WIDTH + 3;
	localparam int NCELL   = ITERATIONS - 1;
	localparam int LATENCY = ITERATIONS + 1;

	logic                 valid_c [0:NCELL];
	cda_ctl_t             ctl_c   [0:NCELL];
	logic signed [IW-1:0] vx_c    [0:NCELL];
	logic signed [IW-1:0] vy_c    [0:NCELL];
	resid_t               resid_c [0:NCELL];

	angle_t angle_d, angle_q;
	logic   done_q;

	assign busy = 1'b0;

	// octant fold
	cda_fold #(
		.CW(COORD_WIDTH),
		.IW(IW)
	) u_fold (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_in(start),
		.x_in    (x_coord),
		.y_in    (y_coord),
		.valid_q (valid_c[0]),
		.ctl_q   (ctl_c[0]),
		.vx_q    (vx_c[0]),
		.vy_q    (vy_c[0])
	);
	assign resid_c[0] = '0;

	// chain of vectoring cells, one per shift from 1 to ITERATIONS - 1
	for (genvar g = 1; g <= NCELL; g++) begin : g_cell
		cda_cell #(
			.IW   (IW),
			.SHIFT(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_in(valid_c[g-1]),
			.ctl_in  (ctl_c[g-1]),
			.vx_in   (vx_c[g-1]),
			.vy_in   (vy_c[g-1]),
			.resid_in(resid_c[g-1]),
			.valid_q (valid_c[g]),
			.ctl_q   (ctl_c[g]),
			.vx_q    (vx_c[g]),
			.vy_q    (vy_c[g]),
			.resid_q (resid_c[g])
		);
	end

	// base plus residual times 180, or the axis value when y is zero
	always_comb begin
		angle_d = base_angle(ctl_c[NCELL].base)
			+ angle_t'(resid_c[NCELL]) * angle_t'(RESID_SCALE);
		if (ctl_c[NCELL].zero_y) begin
			angle_d = ctl_c[NCELL].x_neg ? HALF_TURN : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_c[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		angle_q <= angle_d;
	end

	assign done      = done_q;
	assign angle_deg = angle_q;

`ifndef NO_ASSERTIONS
	// every accepted item comes out with a done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted item did not come out on time");

	// no result without a matching accepted item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result strobe without an accepted item");

	// a vector on the x axis gives 0 or 180 degrees
	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && (y_coord == '0), LATENCY)
		|-> (angle_deg == '0) || (angle_deg == HALF_TURN))
		else $error("vector on the x axis gave an off-axis angle");
`endif

endmodule

[tb/sv/cordic_atan2_degrees_tb.sv]
// Self-checking testbench for cordic_atan2_degrees: directed and random vectors,
// predicted angles compared with each result. Depends on cda_pkg and the RTL only.
`timescale 1ns / 1ps

module cordic_atan2_degrees_tb;
	import cda_pkg::*;

	localparam int ITERATIONS  = 12;
	localparam int COORD_WIDTH = 16;
	localparam int RAND_ITEMS  = 1580;
	localparam int QUIET_LIMIT = 5000;
	localparam int FLUSH_CYCLES = ITERATIONS + 8;

	// atan(2^-i), pi = 0x10000, for the vectoring steps
	localparam logic [15:0] ATAN_LUT [0:15] = '{
		16'h4000, 16'h25C8, 16'h13F6, 16'h0A22, 16'h0516, 16'h028C, 16'h0146, 16'h00A3,
		16'h0051, 16'h0029, 16'h0014, 16'h000A, 16'h0005, 16'h0003, 16'h0001, 16'h0001
	};

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct {
		coord_t x;
		coord_t y;
		bit     drain;	// hold off until the pipe has emptied
	} vec_item_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	coord_t x_coord = '0;
	coord_t y_coord = '0;
	logic   busy;
	logic   done;
	angle_t angle_deg;

	vec_item_t vec_q[$];
	angle_t    angle_q[$];
	bit        item_taken = 1'b0;
	int        sent_count = 0;
	int        quiet_cycles = 0;
	int        err_count = 0;

	cordic_atan2_degrees #(
		.ITERATIONS (ITERATIONS),
		.COORD_WIDTH(COORD_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.x_coord  (x_coord),
		.y_coord  (y_coord),
		.done     (done),
		.angle_deg(angle_deg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected angle: octant fold, vectoring steps, exact degree conversion
	function automatic angle_t vector_angle(input coord_t xin, input coord_t yin);
		longint vx, vy, dx, dy, t, octant, resid, deg;
		vx = longint'(xin);
		vy = longint'(yin);
		octant = 0;
		resid = 0;
		if (vy == 0)
			return (vx >= 0) ? angle_t'(0) : angle_t'(180 * 65536);
		if (vy < 0) begin
			vx = -vx;
			vy = -vy;
			octant += 4;
		end
		if (vx <= 0) begin
			t = vx;
			vx = vy;
			vy = -t;
			octant += 2;
		end
		if (vx <= vy) begin
			t = vy - vx;
			vx = vx + vy;
			vy = t;
			octant += 1;
		end
		for (int i = 1; i < ITERATIONS; i++) begin
			dx = vx >>> (i & 15);
			dy = vy >>> (i & 15);
			if (vy >= 0) begin
				t = vx + dy;
				vy = vy - dx;
				vx = t;
				resid += longint'(ATAN_LUT[i & 15]);
			end else begin
				t = vx - dy;
				vy = vy + dx;
				vx = t;
				resid -= longint'(ATAN_LUT[i & 15]);
			end
		end
		deg = octant * 45 * 65536 + resid * 180;
		return angle_t'(deg);
	endfunction

	function automatic void add_vec(input int xv, input int yv, input bit drain);
		vec_item_t it;
		it.x = coord_t'(xv);
		it.y = coord_t'(yv);
		it.drain = drain;
		vec_q.push_back(it);
	endfunction

	// Driver: present the head item at the falling edge, idle now and then
	always @(negedge clk) begin
		bit        idle;
		bit        drive;
		vec_item_t head;
		if (item_taken) begin
			void'(vec_q.pop_front());
			sent_count++;
		end
		idle = (sent_count < 700 || sent_count >= 1000) && ($urandom_range(99) < 26);
		drive = 1'b0;
		if (arst_n && vec_q.size() != 0 && !idle) begin
			head = vec_q[0];
			drive = !(head.drain && angle_q.size() != 0);
		end
		start <= drive;
		if (drive) begin
			x_coord <= head.x;
			y_coord <= head.y;
		end else if ($urandom_range(1)) begin
			// junk payload while idle
			x_coord <= coord_t'($urandom);
			y_coord <= coord_t'($urandom);
		end
	end

	// Monitor: record accepted items, check each angle against the oldest prediction
	always @(posedge clk) begin
		angle_t want;
		item_taken <= arst_n && start && !busy;
		if (arst_n) begin
			if (done) begin
				if (angle_q.size() == 0) begin
					$error("angle_deg: unexpected result %0d", angle_deg);
					err_count++;
				end else begin
					want = angle_q.pop_front();
					if (angle_deg !== want) begin
						$error("angle_deg: expected %0d, got %0d", want, angle_deg);
						err_count++;
					end
				end
			end
			if (start && !busy)
				angle_q.push_back(vector_angle(x_coord, y_coord));
			// watchdog on cycles with no traffic at all
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int kind;
		int mag;
		// axes, including both ends of the range and the zero vector
		add_vec(0, 0, 1'b0);
		add_vec(1, 0, 1'b0);
		add_vec(-1, 0, 1'b0);
		add_vec(32767, 0, 1'b0);
		add_vec(-32768, 0, 1'b0);
		add_vec(0, 1, 1'b0);
		add_vec(0, -1, 1'b0);
		add_vec(0, 32767, 1'b0);
		add_vec(0, -32768, 1'b0);
		// corners and diagonals in every quadrant
		add_vec(-32768, -32768, 1'b0);
		add_vec(32767, 32767, 1'b0);
		add_vec(-32768, 32767, 1'b0);
		add_vec(32767, -32768, 1'b0);
		add_vec(1, 1, 1'b0);
		add_vec(-1, 1, 1'b0);
		add_vec(-1, -1, 1'b0);
		add_vec(1, -1, 1'b0);
		add_vec(100, 100, 1'b0);
		// just past an octant start: slightly negative residuals, near 360
		add_vec(32767, 1, 1'b0);
		add_vec(32767, -1, 1'b0);
		add_vec(-32768, 1, 1'b0);
		add_vec(1, -32768, 1'b0);
		add_vec(-1, 32767, 1'b0);
		add_vec(20000, 20001, 1'b0);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			kind = $urandom_range(9);
			mag = 1 << $urandom_range(15);
			case (kind)
				0: add_vec($urandom_range(mag) - mag / 2, 0, i % 400 == 0);
				1: add_vec($urandom_range(65535) - 32768, $urandom_range(7) - 4,
					i % 400 == 0);
				2: add_vec($urandom_range(7) - 4, $urandom_range(65535) - 32768,
					i % 400 == 0);
				3: begin
					// near the diagonals
					kind = $urandom_range(65535) - 32768;
					add_vec(kind, ($urandom_range(1) ? kind : -kind) + $urandom_range(6) - 3,
						i % 400 == 0);
				end
				4, 5: add_vec($urandom_range(mag) - mag / 2, $urandom_range(mag) - mag / 2,
					i % 400 == 0);
				default: add_vec($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
					i % 400 == 0);
			endcase
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (vec_q.size() != 0 || angle_q.size() != 0)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);

		if (err_count == 0 && angle_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
